FILE: src/phr_pkg.sv
// Shared constants, types and helpers for the planar heading rate block.
// Used by the attitude rotator and the top level; depends on nothing else.
package phr_pkg;

    localparam int QUAT_FRAC_BITS  = 14;
    localparam int RATE_FRAC_BITS  = 12;
    localparam int RATE_TGT_FRAC   = 24;
    localparam int DIV_EXTRA       = RATE_TGT_FRAC - RATE_FRAC_BITS;
    localparam int QUAT_NORM_MIN   = 3;
    localparam int SQRT_STEPS      = 32;
    localparam int NORM_QBITS      = 15;
    localparam int HD_QBITS        = 43;
    localparam int DEG_PER_RAD_Q15 = 1877468;
    localparam int OUT_SHIFT       = RATE_TGT_FRAC + 15 - 8;
    localparam int ROT_LAT         = 4;

    typedef logic [3:0][15:0] quat_t;
    typedef logic [2:0][15:0] vec16_t;
    typedef logic [2:0][19:0] vec20_t;

    typedef enum logic [1:0] {
        PATH_FWD  = 2'd0,
        PATH_RGT  = 2'd1,
        PATH_NONE = 2'd2
    } path_t;

    typedef enum logic [2:0] {
        CFG_FWD_X  = 3'd0,
        CFG_FWD_Y  = 3'd1,
        CFG_FWD_Z  = 3'd2,
        CFG_RGT_X  = 3'd3,
        CFG_RGT_Y  = 3'd4,
        CFG_RGT_Z  = 3'd5,
        CFG_THRESH = 3'd6
    } cfg_idx_t;

    // Shift right with rounding half away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int unsigned s);
        logic [63:0] m;
        logic [63:0] half;
        half = 64'd1 << (s - 1);
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + half) >> s;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: src/planar_heading_rate_from_attitude_top.sv
// Top level of the planar heading rate block: normalizer, two rotators,
// projection, heading divider and output scaling. Depends on phr_pkg, phr_rotate.
//
// The block takes one request per cycle while the output is not stalled and
// returns one result per request, in order. All work is fully pipelined: the
// longest parts are the 32 stage square root and the 15 stage dividers that
// normalize the quaternion, and the 43 stage heading divider, each one
// quotient bit per stage. A stalled output holds the whole pipeline.
module planar_heading_rate_from_attitude_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [19:0] omega_x,
    input  logic signed [19:0] omega_y,
    input  logic signed [19:0] omega_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] heading_rate,
    output logic [1:0]         path_used,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import phr_pkg::*;

    localparam int HD_LOW = HD_QBITS - DIV_EXTRA;

    typedef struct packed {
        quat_t  q;
        vec20_t w;
        logic   ident;
    } side_t;

    typedef struct packed {
        logic [39:0] den;
        logic        neg;
        logic        sat;
        path_t       path;
    } hdc_t;

    logic   adv;
    vec16_t fwd_reg, rgt_reg;
    logic [15:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= {16'd0, 16'd0, 16'(1 << QUAT_FRAC_BITS)};
            rgt_reg <= {16'd0, 16'(1 << QUAT_FRAC_BITS), 16'd0};
            thr_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FWD_X:  fwd_reg[0] <= cfg_data;
                CFG_FWD_Y:  fwd_reg[1] <= cfg_data;
                CFG_FWD_Z:  fwd_reg[2] <= cfg_data;
                CFG_RGT_X:  rgt_reg[0] <= cfg_data;
                CFG_RGT_Y:  rgt_reg[1] <= cfg_data;
                CFG_RGT_Z:  rgt_reg[2] <= cfg_data;
                CFG_THRESH: thr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input and square stages.
    side_t              a_side_reg, b_side_reg;
    logic signed [31:0] b_sq_reg [0:3];
    logic signed [31:0] b_sq_next [0:3];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b_sq_next[i] = $signed(a_side_reg.q[i]) * $signed(a_side_reg.q[i]);
        end
    end

    // Square root pipeline.
    logic [63:0] sx_reg [0:SQRT_STEPS];
    logic [63:0] sx_next [0:SQRT_STEPS];
    logic [63:0] sr_reg [0:SQRT_STEPS];
    logic [63:0] sr_next [0:SQRT_STEPS];
    side_t       ss_reg [0:SQRT_STEPS];
    side_t       ss_next [0:SQRT_STEPS];

    always_comb
    begin
        logic [32:0] nsum;
        logic [63:0] bk;
        logic [63:0] tk;
        nsum = 33'(b_sq_reg[0][30:0]) + 33'(b_sq_reg[1][30:0])
             + 33'(b_sq_reg[2][30:0]) + 33'(b_sq_reg[3][30:0]);
        sx_next[0] = {1'b0, nsum, 30'd0};
        sr_next[0] = 64'd0;
        ss_next[0] = b_side_reg;
        ss_next[0].ident = (nsum < 33'(QUAT_NORM_MIN));
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bk = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
            tk = sr_reg[k] + bk;
            if (sx_reg[k] >= tk)
            begin
                sx_next[k + 1] = sx_reg[k] - tk;
                sr_next[k + 1] = (sr_reg[k] >> 1) + bk;
            end
            else
            begin
                sx_next[k + 1] = sx_reg[k];
                sr_next[k + 1] = sr_reg[k] >> 1;
            end
            ss_next[k + 1] = ss_reg[k];
        end
    end

    // Normalizing dividers, one per quaternion part.
    logic [32:0] dn_rem_reg [0:NORM_QBITS][0:3];
    logic [32:0] dn_rem_next [0:NORM_QBITS][0:3];
    logic [14:0] dn_low_reg [0:NORM_QBITS][0:3];
    logic [14:0] dn_low_next [0:NORM_QBITS][0:3];
    logic [14:0] dn_quo_reg [0:NORM_QBITS][0:3];
    logic [14:0] dn_quo_next [0:NORM_QBITS][0:3];
    logic [32:0] dn_den_reg [0:NORM_QBITS];
    logic [32:0] dn_den_next [0:NORM_QBITS];
    side_t       dn_side_reg [0:NORM_QBITS];
    side_t       dn_side_next [0:NORM_QBITS];

    always_comb
    begin
        logic [31:0] r;
        logic [15:0] mag;
        logic [46:0] nw;
        logic [33:0] trial;
        r = sr_reg[SQRT_STEPS][31:0];
        dn_den_next[0] = {r, 1'b0};
        dn_side_next[0] = ss_reg[SQRT_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            mag = ss_reg[SQRT_STEPS].q[i][15] ? 16'(-$signed(ss_reg[SQRT_STEPS].q[i]))
                                              : ss_reg[SQRT_STEPS].q[i];
            nw = 47'({mag, 30'd0}) + 47'(r);
            dn_rem_next[0][i] = 33'(nw[46:15]);
            dn_low_next[0][i] = nw[14:0];
            dn_quo_next[0][i] = 15'd0;
        end
        for (int j = 0; j < NORM_QBITS; j++)
        begin
            dn_den_next[j + 1] = dn_den_reg[j];
            dn_side_next[j + 1] = dn_side_reg[j];
            for (int i = 0; i < 4; i++)
            begin
                trial = {dn_rem_reg[j][i], dn_low_reg[j][i][14]};
                dn_low_next[j + 1][i] = {dn_low_reg[j][i][13:0], 1'b0};
                if (trial >= {1'b0, dn_den_reg[j]})
                begin
                    dn_rem_next[j + 1][i] = 33'(trial - {1'b0, dn_den_reg[j]});
                    dn_quo_next[j + 1][i] = {dn_quo_reg[j][i][13:0], 1'b1};
                end
                else
                begin
                    dn_rem_next[j + 1][i] = trial[32:0];
                    dn_quo_next[j + 1][i] = {dn_quo_reg[j][i][13:0], 1'b0};
                end
            end
        end
    end

    // Normalized quaternion.
    quat_t  nq_reg, nq_next;
    vec20_t nw_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dn_side_reg[NORM_QBITS].ident)
            begin
                nq_next[i] = (i == 0) ? 16'(1 << QUAT_FRAC_BITS) : 16'd0;
            end
            else if (dn_side_reg[NORM_QBITS].q[i][15])
            begin
                nq_next[i] = 16'(-$signed({1'b0, dn_quo_reg[NORM_QBITS][i]}));
            end
            else
            begin
                nq_next[i] = {1'b0, dn_quo_reg[NORM_QBITS][i]};
            end
        end
    end

    vec20_t df, dr;
    vec20_t rw_reg [0:ROT_LAT - 1];

    phr_rotate u_rot_fwd (
        .clk  (clk),
        .adv  (adv),
        .q    (nq_reg),
        .axis (fwd_reg),
        .d    (df)
    );

    phr_rotate u_rot_rgt (
        .clk  (clk),
        .adv  (adv),
        .q    (nq_reg),
        .axis (rgt_reg),
        .d    (dr)
    );

    // Axis rate and horizontal magnitude for both axes.
    logic signed [39:0] ep_reg [0:1][0:3];
    logic signed [39:0] ep_next [0:1][0:3];
    logic signed [39:0] esq_reg [0:1][0:1];
    logic signed [39:0] esq_next [0:1][0:1];
    logic signed [19:0] ed_reg [0:1][0:1];
    logic signed [19:0] ed_next [0:1][0:1];

    always_comb
    begin
        vec20_t dv;
        vec20_t wv;
        wv = rw_reg[ROT_LAT - 1];
        for (int a = 0; a < 2; a++)
        begin
            dv = (a == 0) ? df : dr;
            ep_next[a][0] = $signed(wv[1]) * $signed(dv[2]);
            ep_next[a][1] = $signed(wv[2]) * $signed(dv[1]);
            ep_next[a][2] = $signed(wv[2]) * $signed(dv[0]);
            ep_next[a][3] = $signed(wv[0]) * $signed(dv[2]);
            esq_next[a][0] = $signed(dv[0]) * $signed(dv[0]);
            esq_next[a][1] = $signed(dv[1]) * $signed(dv[1]);
            ed_next[a][0] = $signed(dv[0]);
            ed_next[a][1] = $signed(dv[1]);
        end
    end

    logic signed [40:0] frx_reg [0:1];
    logic signed [40:0] frx_next [0:1];
    logic signed [40:0] fry_reg [0:1];
    logic signed [40:0] fry_next [0:1];
    logic [39:0]        fden_reg [0:1];
    logic [39:0]        fden_next [0:1];
    logic signed [19:0] fd_reg [0:1][0:1];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            frx_next[a] = 41'(ep_reg[a][0]) - 41'(ep_reg[a][1]);
            fry_next[a] = 41'(ep_reg[a][2]) - 41'(ep_reg[a][3]);
            fden_next[a] = 40'(esq_reg[a][0]) + 40'(esq_reg[a][1]);
        end
    end

    // Path selection.
    logic signed [19:0] g_d0_reg, g_d0_next, g_d1_reg, g_d1_next;
    logic signed [40:0] g_rx_reg, g_rx_next, g_ry_reg, g_ry_next;
    logic [39:0]        g_den_reg, g_den_next;
    path_t              g_path_reg, g_path_next;

    always_comb
    begin
        logic ok_f;
        logic ok_r;
        logic sel;
        ok_f = fden_reg[0] > {24'd0, thr_reg};
        ok_r = fden_reg[1] > {24'd0, thr_reg};
        sel = !ok_f;
        g_path_next = ok_f ? PATH_FWD : (ok_r ? PATH_RGT : PATH_NONE);
        g_d0_next = fd_reg[sel][0];
        g_d1_next = fd_reg[sel][1];
        g_rx_next = frx_reg[sel];
        g_ry_next = fry_reg[sel];
        g_den_next = fden_reg[sel];
    end

    // Numerator.
    logic signed [60:0] h_p1_reg, h_p1_next, h_p2_reg, h_p2_next;
    hdc_t               h_ctl_reg, h_ctl_next;
    logic signed [61:0] i_num_reg, i_num_next;
    hdc_t               i_ctl_reg;
    logic [61:0]        j_m_reg, j_m_next;
    hdc_t               j_ctl_reg, j_ctl_next;

    always_comb
    begin
        h_p1_next = g_d0_reg * g_ry_reg;
        h_p2_next = g_d1_reg * g_rx_reg;
        h_ctl_next.den = g_den_reg;
        h_ctl_next.neg = 1'b0;
        h_ctl_next.sat = 1'b0;
        h_ctl_next.path = g_path_reg;
        i_num_next = 62'(h_p1_reg) - 62'(h_p2_reg);
        j_ctl_next = i_ctl_reg;
        j_ctl_next.neg = i_num_reg[61];
        j_m_next = i_num_reg[61] ? 62'(-i_num_reg) : 62'(i_num_reg);
    end

    // Heading divider.
    logic [39:0]         hd_rem_reg [0:HD_QBITS];
    logic [39:0]         hd_rem_next [0:HD_QBITS];
    logic [HD_QBITS-1:0] hd_low_reg [0:HD_QBITS];
    logic [HD_QBITS-1:0] hd_low_next [0:HD_QBITS];
    logic [HD_QBITS-1:0] hd_quo_reg [0:HD_QBITS];
    logic [HD_QBITS-1:0] hd_quo_next [0:HD_QBITS];
    hdc_t                hd_ctl_reg [0:HD_QBITS];
    hdc_t                hd_ctl_next [0:HD_QBITS];

    always_comb
    begin
        logic [30:0] hi;
        logic [40:0] trial;
        hi = j_m_reg[61:HD_LOW];
        hd_ctl_next[0] = j_ctl_reg;
        hd_ctl_next[0].sat = {9'd0, hi} >= j_ctl_reg.den;
        hd_rem_next[0] = hd_ctl_next[0].sat ? 40'd0 : 40'(hi);
        hd_low_next[0] = {j_m_reg[HD_LOW-1:0], {DIV_EXTRA{1'b0}}};
        hd_quo_next[0] = '0;
        for (int j = 0; j < HD_QBITS; j++)
        begin
            hd_ctl_next[j + 1] = hd_ctl_reg[j];
            trial = {hd_rem_reg[j], hd_low_reg[j][HD_QBITS-1]};
            hd_low_next[j + 1] = {hd_low_reg[j][HD_QBITS-2:0], 1'b0};
            if (trial >= {1'b0, hd_ctl_reg[j].den})
            begin
                hd_rem_next[j + 1] = 40'(trial - {1'b0, hd_ctl_reg[j].den});
                hd_quo_next[j + 1] = {hd_quo_reg[j][HD_QBITS-2:0], 1'b1};
            end
            else
            begin
                hd_rem_next[j + 1] = trial[39:0];
                hd_quo_next[j + 1] = {hd_quo_reg[j][HD_QBITS-2:0], 1'b0};
            end
        end
    end

    // Rounding, scaling to degrees and saturation.
    logic [HD_QBITS-1:0] k_q_reg, k_q_next;
    hdc_t                k_ctl_reg, l_ctl_reg, m_ctl_reg;
    logic [42:0]         l_lo_reg, l_lo_next;
    logic [41:0]         l_hi_reg, l_hi_next;
    logic [32:0]         m_mag_reg, m_mag_next;
    logic signed [31:0]  o_rate_reg, o_rate_next;
    path_t               o_path_reg;

    always_comb
    begin
        logic                up;
        logic [HD_QBITS:0]   qsum;
        logic [HD_QBITS-1:0] cap;
        logic [63:0]         acc;
        cap = HD_QBITS'(1) << (HD_QBITS - 1);
        up = {hd_rem_reg[HD_QBITS], 1'b0} >= {1'b0, hd_ctl_reg[HD_QBITS].den};
        qsum = (HD_QBITS + 1)'(hd_quo_reg[HD_QBITS]) + (HD_QBITS + 1)'(up);
        if (hd_ctl_reg[HD_QBITS].sat || qsum > (HD_QBITS + 1)'(cap))
        begin
            k_q_next = cap;
        end
        else
        begin
            k_q_next = qsum[HD_QBITS-1:0];
        end
        l_lo_next = 43'(k_q_reg[21:0]) * 43'(DEG_PER_RAD_Q15);
        l_hi_next = 42'(k_q_reg[42:22]) * 42'(DEG_PER_RAD_Q15);
        acc = {l_hi_reg[41:0], 22'd0} + 64'(l_lo_reg) + (64'd1 << (OUT_SHIFT - 1));
        m_mag_next = acc[OUT_SHIFT+32:OUT_SHIFT];
        if (m_ctl_reg.path == PATH_NONE)
        begin
            o_rate_next = 32'sd0;
        end
        else if (m_ctl_reg.neg)
        begin
            if (m_mag_reg > 33'h0_8000_0000)
            begin
                o_rate_next = 32'sh8000_0000;
            end
            else
            begin
                o_rate_next = $signed(32'(~m_mag_reg + 33'd1));
            end
        end
        else if (m_mag_reg > 33'h0_7FFF_FFFF)
        begin
            o_rate_next = 32'sh7FFF_FFFF;
        end
        else
        begin
            o_rate_next = $signed(m_mag_reg[31:0]);
        end
    end

    // Valid bits travel alongside the data.
    logic a_vld_reg, b_vld_reg, n_vld_reg;
    logic sv_reg [0:SQRT_STEPS];
    logic dv_reg [0:NORM_QBITS];
    logic rv_reg [0:ROT_LAT - 1];
    logic e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg;
    logic hv_reg [0:HD_QBITS];
    logic k_vld_reg, l_vld_reg, m_vld_reg, o_vld_reg;

    assign adv      = !(o_vld_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) sv_reg[k] <= 1'b0;
            for (int k = 0; k <= NORM_QBITS; k++) dv_reg[k] <= 1'b0;
            for (int k = 0; k < ROT_LAT; k++) rv_reg[k] <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            for (int k = 0; k <= HD_QBITS; k++) hv_reg[k] <= 1'b0;
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            sv_reg[0] <= b_vld_reg;
            for (int k = 0; k < SQRT_STEPS; k++) sv_reg[k + 1] <= sv_reg[k];
            dv_reg[0] <= sv_reg[SQRT_STEPS];
            for (int k = 0; k < NORM_QBITS; k++) dv_reg[k + 1] <= dv_reg[k];
            n_vld_reg <= dv_reg[NORM_QBITS];
            rv_reg[0] <= n_vld_reg;
            for (int k = 0; k < ROT_LAT - 1; k++) rv_reg[k + 1] <= rv_reg[k];
            e_vld_reg <= rv_reg[ROT_LAT - 1];
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
            hv_reg[0] <= j_vld_reg;
            for (int k = 0; k < HD_QBITS; k++) hv_reg[k + 1] <= hv_reg[k];
            k_vld_reg <= hv_reg[HD_QBITS];
            l_vld_reg <= k_vld_reg;
            m_vld_reg <= l_vld_reg;
            o_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.q     <= {quat_z, quat_y, quat_x, quat_w};
            a_side_reg.w     <= {omega_z, omega_y, omega_x};
            a_side_reg.ident <= 1'b0;
            b_side_reg       <= a_side_reg;
            for (int i = 0; i < 4; i++) b_sq_reg[i] <= b_sq_next[i];
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                sx_reg[k] <= sx_next[k];
                sr_reg[k] <= sr_next[k];
                ss_reg[k] <= ss_next[k];
            end
            for (int j = 0; j <= NORM_QBITS; j++)
            begin
                dn_den_reg[j]  <= dn_den_next[j];
                dn_side_reg[j] <= dn_side_next[j];
                for (int i = 0; i < 4; i++)
                begin
                    dn_rem_reg[j][i] <= dn_rem_next[j][i];
                    dn_low_reg[j][i] <= dn_low_next[j][i];
                    dn_quo_reg[j][i] <= dn_quo_next[j][i];
                end
            end
            nq_reg    <= nq_next;
            nw_reg    <= dn_side_reg[NORM_QBITS].w;
            rw_reg[0] <= nw_reg;
            for (int k = 0; k < ROT_LAT - 1; k++) rw_reg[k + 1] <= rw_reg[k];
            for (int a = 0; a < 2; a++)
            begin
                for (int i = 0; i < 4; i++) ep_reg[a][i] <= ep_next[a][i];
                for (int i = 0; i < 2; i++)
                begin
                    esq_reg[a][i] <= esq_next[a][i];
                    ed_reg[a][i]  <= ed_next[a][i];
                    fd_reg[a][i]  <= ed_reg[a][i];
                end
                frx_reg[a]  <= frx_next[a];
                fry_reg[a]  <= fry_next[a];
                fden_reg[a] <= fden_next[a];
            end
            g_d0_reg   <= g_d0_next;
            g_d1_reg   <= g_d1_next;
            g_rx_reg   <= g_rx_next;
            g_ry_reg   <= g_ry_next;
            g_den_reg  <= g_den_next;
            g_path_reg <= g_path_next;
            h_p1_reg   <= h_p1_next;
            h_p2_reg   <= h_p2_next;
            h_ctl_reg  <= h_ctl_next;
            i_num_reg  <= i_num_next;
            i_ctl_reg  <= h_ctl_reg;
            j_m_reg    <= j_m_next;
            j_ctl_reg  <= j_ctl_next;
            for (int j = 0; j <= HD_QBITS; j++)
            begin
                hd_rem_reg[j] <= hd_rem_next[j];
                hd_low_reg[j] <= hd_low_next[j];
                hd_quo_reg[j] <= hd_quo_next[j];
                hd_ctl_reg[j] <= hd_ctl_next[j];
            end
            k_q_reg    <= k_q_next;
            k_ctl_reg  <= hd_ctl_reg[HD_QBITS];
            l_lo_reg   <= l_lo_next;
            l_hi_reg   <= l_hi_next;
            l_ctl_reg  <= k_ctl_reg;
            m_mag_reg  <= m_mag_next;
            m_ctl_reg  <= l_ctl_reg;
            o_rate_reg <= o_rate_next;
            o_path_reg <= m_ctl_reg.path;
        end
    end

    assign out_valid    = o_vld_reg;
    assign heading_rate = o_rate_reg;
    assign path_used    = o_path_reg;

endmodule

FILE: src/phr_rotate.sv
// Four stage pipelined rotation of a fixed body axis by a unit quaternion.
// Depends on phr_pkg for the fraction width, vector types and rounding.
module phr_rotate (
    input  logic           clk,
    input  logic           adv,
    input  phr_pkg::quat_t q,
    input  phr_pkg::vec16_t axis,
    output phr_pkg::vec20_t d
);
    import phr_pkg::*;

    logic signed [31:0] c_reg [0:5];
    logic signed [31:0] c_next [0:5];
    quat_t              q1_reg, q2_reg;
    logic signed [17:0] t_reg [0:2];
    logic signed [17:0] t_next [0:2];
    logic signed [33:0] e_reg [0:5];
    logic signed [33:0] e_next [0:5];
    logic signed [33:0] qt_reg [0:2];
    logic signed [33:0] qt_next [0:2];
    vec20_t             d_reg, d_next;

    always_comb
    begin
        logic signed [15:0] v0, v1, v2;
        v0 = $signed(axis[0]);
        v1 = $signed(axis[1]);
        v2 = $signed(axis[2]);
        c_next[0] = $signed(q[2]) * v2;
        c_next[1] = $signed(q[3]) * v1;
        c_next[2] = $signed(q[3]) * v0;
        c_next[3] = $signed(q[1]) * v2;
        c_next[4] = $signed(q[1]) * v1;
        c_next[5] = $signed(q[2]) * v0;
    end

    always_comb
    begin
        logic signed [63:0] tw;
        for (int i = 0; i < 3; i++)
        begin
            tw = rnd_shift((64'(c_reg[2 * i]) - 64'(c_reg[2 * i + 1])) <<< 1,
                           QUAT_FRAC_BITS);
            t_next[i] = $signed(tw[17:0]);
        end
    end

    always_comb
    begin
        e_next[0] = $signed(q2_reg[2]) * t_reg[2];
        e_next[1] = $signed(q2_reg[3]) * t_reg[1];
        e_next[2] = $signed(q2_reg[3]) * t_reg[0];
        e_next[3] = $signed(q2_reg[1]) * t_reg[2];
        e_next[4] = $signed(q2_reg[1]) * t_reg[1];
        e_next[5] = $signed(q2_reg[2]) * t_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            qt_next[i] = $signed(q2_reg[0]) * t_reg[i];
        end
    end

    always_comb
    begin
        logic signed [63:0] acc;
        logic signed [63:0] dw;
        logic signed [15:0] vi;
        for (int i = 0; i < 3; i++)
        begin
            vi = $signed(axis[i]);
            acc = (64'(vi) <<< QUAT_FRAC_BITS) + 64'(qt_reg[i])
                + 64'(e_reg[2 * i]) - 64'(e_reg[2 * i + 1]);
            dw = rnd_shift(acc, QUAT_FRAC_BITS);
            d_next[i] = dw[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                c_reg[i] <= c_next[i];
                e_reg[i] <= e_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i]  <= t_next[i];
                qt_reg[i] <= qt_next[i];
            end
            q1_reg <= q;
            q2_reg <= q1_reg;
            d_reg  <= d_next;
        end
    end

    assign d = d_reg;

endmodule
